### design/smat_pkg.sv
// Shared types and constants for the swap move availability table.
package smat_pkg;

  // Default number of facilities tracked
  localparam int FACILITIES_DEF = 256;

  // Field widths fixed by the request and result formats
  localparam int FAC_W = 8;
  localparam int CNT_W = 9;

  // Request modes
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_MOVE = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // Per-facility marks, kept together in one memory word
  typedef struct packed {
    logic used;
    logic ins;
    logic rem;
  } mark_t;

  // Latched request payload
  typedef struct packed {
    logic [1:0]       mode;
    logic [FAC_W-1:0] facility;
    logic             in_solution;
    logic             in_target;
    logic             insert_valid;
    logic [FAC_W-1:0] insert_facility;
    logic             remove_valid;
    logic [FAC_W-1:0] remove_facility;
    logic [FAC_W-1:0] position;
  } req_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RD_ISSUE,
    ST_RD_DATA,
    ST_MV_MARK_I,
    ST_MV_MARK_R,
    ST_MV_CHECK,
    ST_MV_SCAN,
    ST_MV_LAST,
    ST_MV_SWAP,
    ST_MV_APPEND,
    ST_DONE
  } state_t;

endpackage

### design/smat_in_if.sv
// Request channel: valid/ready handshake with the request fields.
interface smat_in_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              mode;
  logic [smat_pkg::FAC_W-1:0] facility;
  logic                    in_solution;
  logic                    in_target;
  logic                    insert_valid;
  logic [smat_pkg::FAC_W-1:0] insert_facility;
  logic                    remove_valid;
  logic [smat_pkg::FAC_W-1:0] remove_facility;
  logic [smat_pkg::FAC_W-1:0] position;

  modport source (
    output valid, mode, facility, in_solution, in_target, insert_valid,
           insert_facility, remove_valid, remove_facility, position,
    input  ready
  );

  modport sink (
    input  valid, mode, facility, in_solution, in_target, insert_valid,
           insert_facility, remove_valid, remove_facility, position,
    output ready
  );
endinterface

### design/smat_out_if.sv
// Result channel: valid/ready handshake with the result fields.
interface smat_out_if;
  logic                       valid;
  logic                       ready;
  logic [smat_pkg::CNT_W-1:0] insert_count;
  logic [smat_pkg::CNT_W-1:0] remove_count;
  logic [smat_pkg::FAC_W-1:0] insert_entry;
  logic [smat_pkg::FAC_W-1:0] remove_entry;
  logic                       error;

  modport source (
    output valid, insert_count, remove_count, insert_entry, remove_entry, error,
    input  ready
  );

  modport sink (
    input  valid, insert_count, remove_count, insert_entry, remove_entry, error,
    output ready
  );
endinterface

### design/swap_move_availability_table.sv
// Top level of the swap move availability table.
//
// Usage: requests arrive on in_ch (valid/ready), one result per request
// leaves on out_ch (valid/ready). cfg_we/cfg_wdata write the path
// relinking flag; write it only while the block is idle.
// A load request carries one facility (ascending from 0, facility 0 restarts
// both lists) and sets its marks and list entries. A move request
// swap-removes the inserted and removed facilities from their lists and,
// with path relinking off, appends them to the opposite lists. A read
// request returns one entry of each list.
// A move searches both lists, comparing one entry of each list per cycle
// through the single read port of each list. One request is in work at a
// time; in_ch.ready is high only when idle. A finished result sits in
// the output register while the next request is accepted; if the
// receiver stalls, the block holds its next result until the output
// register frees up.
// Reset (rst_n low, synchronous) empties both lists, clears all marks
// through per-entry valid bits at once, and clears path relinking; no
// clearing pass is needed.
module swap_move_availability_table #(
  parameter int FACILITIES = smat_pkg::FACILITIES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  smat_in_if.sink         in_ch,
  smat_out_if.source      out_ch,
  input  logic            cfg_we,
  input  logic            cfg_wdata
);

  localparam int AW     = $clog2(FACILITIES);
  localparam int CW     = $clog2(FACILITIES + 1);
  localparam int MDEPTH = (FACILITIES < 256) ? FACILITIES : 256;
  localparam int MAW    = $clog2(MDEPTH);
  localparam int FW     = smat_pkg::FAC_W;

  // ---------------------------------------------------------------------
  // Registers
  smat_pkg::state_t state_r, state_nxt;
  smat_pkg::req_t   req_r, req_nxt;
  logic             prl_r;
  logic [CW-1:0]    ins_tot_r, ins_tot_nxt;
  logic [CW-1:0]    rem_tot_r, rem_tot_nxt;
  logic             mark_vld_r [MDEPTH];
  logic             mark_rvld_r;
  smat_pkg::mark_t  mi_r, mi_nxt;
  smat_pkg::mark_t  mr_r, mr_nxt;
  logic             err_r, err_nxt;
  logic [FW-1:0]    ie_r, ie_nxt;
  logic [FW-1:0]    re_r, re_nxt;
  logic [CW-1:0]    scan_r, scan_nxt;
  logic             pend_r, pend_nxt;
  logic [CW-1:0]    pend_idx_r, pend_idx_nxt;
  logic             fnd_i_r, fnd_i_nxt;
  logic             fnd_r_r, fnd_r_nxt;
  logic [AW-1:0]    ip_r, ip_nxt;
  logic [AW-1:0]    rp_r, rp_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [smat_pkg::CNT_W-1:0] out_ic_r, out_ic_nxt;
  logic [smat_pkg::CNT_W-1:0] out_rc_r, out_rc_nxt;
  logic [FW-1:0]    out_ie_r, out_ie_nxt;
  logic [FW-1:0]    out_re_r, out_re_nxt;
  logic             out_err_r, out_err_nxt;

  // Memory ports
  logic             ins_we, rem_we, mark_we;
  logic [AW-1:0]    ins_waddr, rem_waddr, ins_raddr, rem_raddr;
  logic [FW-1:0]    ins_wdata, rem_wdata, ins_rdata, rem_rdata;
  logic [MAW-1:0]   mark_waddr, mark_raddr;
  smat_pkg::mark_t  mark_wdata, mark_rdata, mark_rd;

  // ---------------------------------------------------------------------
  // Memories: two facility lists and the mark table
  smat_ram #(.WIDTH(FW), .DEPTH(FACILITIES)) u_ins_list (
    .clk(clk), .we(ins_we), .waddr(ins_waddr), .wdata(ins_wdata),
    .raddr(ins_raddr), .rdata(ins_rdata)
  );

  smat_ram #(.WIDTH(FW), .DEPTH(FACILITIES)) u_rem_list (
    .clk(clk), .we(rem_we), .waddr(rem_waddr), .wdata(rem_wdata),
    .raddr(rem_raddr), .rdata(rem_rdata)
  );

  smat_ram #(.WIDTH($bits(smat_pkg::mark_t)), .DEPTH(MDEPTH)) u_marks (
    .clk(clk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
    .raddr(mark_raddr), .rdata(mark_rdata)
  );

  // A mark entry never written since reset reads as all zero
  assign mark_rd = mark_rvld_r ? mark_rdata : '0;

  // ---------------------------------------------------------------------
  // Request decode
  logic          in_acc, out_take;
  logic          iv, rv, restore;
  logic          f_ok, fi_ok, fr_ok;
  logic [CW-1:0] new_ins, new_rem;
  logic          chk_fail;

  assign in_ch.ready = (state_r == smat_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_take    = !out_vld_r || out_ch.ready;

  assign iv      = req_r.insert_valid;
  assign rv      = req_r.remove_valid;
  assign restore = !prl_r;
  assign f_ok    = (32'(req_r.facility) < 32'(FACILITIES));
  assign fi_ok   = (32'(req_r.insert_facility) < 32'(FACILITIES));
  assign fr_ok   = (32'(req_r.remove_facility) < 32'(FACILITIES));
  assign new_ins = ins_tot_r - CW'(iv);
  assign new_rem = rem_tot_r - CW'(rv);

  // Move preconditions on marks and list room (fr marks arrive in CHECK)
  assign chk_fail =
      (iv && (!fi_ok || mi_r.used || !mi_r.ins || (restore && mi_r.rem))) ||
      (rv && (!fr_ok || !mark_rd.used || !mark_rd.rem || (restore && mark_rd.ins))) ||
      (restore && iv && (32'(new_rem) >= 32'(FACILITIES))) ||
      (restore && rv && (32'(new_ins) >= 32'(FACILITIES)));

  // ---------------------------------------------------------------------
  // List search: one entry of each list per cycle, compared in the next cycle
  logic [CW-1:0] scan_lim;
  logic          scan_issue, cmp_i, cmp_r, fnd_i_now, fnd_r_now;
  logic          all_found, scan_exit;

  assign scan_lim = ((iv && ins_tot_r >= rem_tot_r) || !rv) ?
                    (iv ? ins_tot_r : '0) : rem_tot_r;
  assign scan_issue = (scan_r < scan_lim);
  assign cmp_i = pend_r && iv && !fnd_i_r && (pend_idx_r < ins_tot_r) &&
                 (ins_rdata == req_r.insert_facility);
  assign cmp_r = pend_r && rv && !fnd_r_r && (pend_idx_r < rem_tot_r) &&
                 (rem_rdata == req_r.remove_facility);
  assign fnd_i_now = fnd_i_r || cmp_i;
  assign fnd_r_now = fnd_r_r || cmp_r;
  assign all_found = (fnd_i_now || !iv) && (fnd_r_now || !rv);
  assign scan_exit = all_found || (!pend_r && !scan_issue);

  // ---------------------------------------------------------------------
  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      smat_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          unique case (in_ch.mode)
            smat_pkg::MODE_LOAD: state_nxt = smat_pkg::ST_LOAD;
            smat_pkg::MODE_MOVE: state_nxt = smat_pkg::ST_MV_MARK_I;
            smat_pkg::MODE_READ: state_nxt = smat_pkg::ST_RD_ISSUE;
            default:             state_nxt = smat_pkg::ST_DONE;
          endcase
        end
      end
      smat_pkg::ST_LOAD:      state_nxt = smat_pkg::ST_DONE;
      smat_pkg::ST_RD_ISSUE:  state_nxt = smat_pkg::ST_RD_DATA;
      smat_pkg::ST_RD_DATA:   state_nxt = smat_pkg::ST_DONE;
      smat_pkg::ST_MV_MARK_I: state_nxt = smat_pkg::ST_MV_MARK_R;
      smat_pkg::ST_MV_MARK_R: state_nxt = smat_pkg::ST_MV_CHECK;
      smat_pkg::ST_MV_CHECK: begin
        if (chk_fail || !(iv || rv)) begin
          state_nxt = smat_pkg::ST_DONE;
        end else begin
          state_nxt = smat_pkg::ST_MV_SCAN;
        end
      end
      smat_pkg::ST_MV_SCAN: begin
        if (scan_exit) begin
          state_nxt = all_found ? smat_pkg::ST_MV_LAST : smat_pkg::ST_DONE;
        end
      end
      smat_pkg::ST_MV_LAST:   state_nxt = smat_pkg::ST_MV_SWAP;
      smat_pkg::ST_MV_SWAP:   state_nxt = smat_pkg::ST_MV_APPEND;
      smat_pkg::ST_MV_APPEND: state_nxt = smat_pkg::ST_DONE;
      smat_pkg::ST_DONE: begin
        if (out_take) begin
          state_nxt = smat_pkg::ST_IDLE;
        end
      end
      default: state_nxt = smat_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Datapath control per state
  logic          ld_ins, ld_rem;
  logic [CW-1:0] ld_ibase, ld_rbase;

  assign ld_ins   = !req_r.in_solution && (!prl_r || req_r.in_target);
  assign ld_rem   = req_r.in_solution && (!prl_r || !req_r.in_target);
  assign ld_ibase = (req_r.facility == '0) ? '0 : ins_tot_r;
  assign ld_rbase = (req_r.facility == '0) ? '0 : rem_tot_r;

  always_comb begin
    req_nxt      = req_r;
    ins_tot_nxt  = ins_tot_r;
    rem_tot_nxt  = rem_tot_r;
    mi_nxt       = mi_r;
    mr_nxt       = mr_r;
    err_nxt      = err_r;
    ie_nxt       = ie_r;
    re_nxt       = re_r;
    scan_nxt     = scan_r;
    pend_nxt     = 1'b0;
    pend_idx_nxt = pend_idx_r;
    fnd_i_nxt    = fnd_i_r;
    fnd_r_nxt    = fnd_r_r;
    ip_nxt       = ip_r;
    rp_nxt       = rp_r;
    ins_we       = 1'b0;
    rem_we       = 1'b0;
    mark_we      = 1'b0;
    ins_waddr    = ins_tot_r[AW-1:0];
    rem_waddr    = rem_tot_r[AW-1:0];
    ins_wdata    = req_r.remove_facility;
    rem_wdata    = req_r.insert_facility;
    ins_raddr    = scan_r[AW-1:0];
    rem_raddr    = scan_r[AW-1:0];
    mark_waddr   = MAW'(req_r.insert_facility);
    mark_wdata   = '0;
    mark_raddr   = MAW'(req_r.insert_facility);
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_ic_nxt   = out_ic_r;
    out_rc_nxt   = out_rc_r;
    out_ie_nxt   = out_ie_r;
    out_re_nxt   = out_re_r;
    out_err_nxt  = out_err_r;

    unique case (state_r)
      // latch request
      smat_pkg::ST_IDLE: begin
        if (in_acc) begin
          req_nxt.mode            = in_ch.mode;
          req_nxt.facility        = in_ch.facility;
          req_nxt.in_solution     = in_ch.in_solution;
          req_nxt.in_target       = in_ch.in_target;
          req_nxt.insert_valid    = in_ch.insert_valid;
          req_nxt.insert_facility = in_ch.insert_facility;
          req_nxt.remove_valid    = in_ch.remove_valid;
          req_nxt.remove_facility = in_ch.remove_facility;
          req_nxt.position        = in_ch.position;
          err_nxt = 1'b0;
          ie_nxt  = '0;
          re_nxt  = '0;
        end
      end

      // load: set marks, append to lists
      smat_pkg::ST_LOAD: begin
        if (!f_ok) begin
          err_nxt = 1'b1;
        end else begin
          mark_we         = 1'b1;
          mark_waddr      = MAW'(req_r.facility);
          mark_wdata.used = req_r.in_solution;
          mark_wdata.ins  = ld_ins;
          mark_wdata.rem  = ld_rem;
          ins_tot_nxt     = ld_ibase;
          rem_tot_nxt     = ld_rbase;
          ins_waddr       = ld_ibase[AW-1:0];
          rem_waddr       = ld_rbase[AW-1:0];
          ins_wdata       = req_r.facility;
          rem_wdata       = req_r.facility;
          if (ld_ins && (32'(ld_ibase) < 32'(FACILITIES))) begin
            ins_we      = 1'b1;
            ins_tot_nxt = ld_ibase + CW'(1);
          end
          if (ld_rem && (32'(ld_rbase) < 32'(FACILITIES))) begin
            rem_we      = 1'b1;
            rem_tot_nxt = ld_rbase + CW'(1);
          end
        end
      end

      // read: fetch both lists at the position
      smat_pkg::ST_RD_ISSUE: begin
        ins_raddr = AW'(req_r.position);
        rem_raddr = AW'(req_r.position);
      end
      smat_pkg::ST_RD_DATA: begin
        if (32'(req_r.position) < 32'(ins_tot_r)) begin
          ie_nxt = ins_rdata;
        end
        if (32'(req_r.position) < 32'(rem_tot_r)) begin
          re_nxt = rem_rdata;
        end
      end

      // move: fetch marks of both facilities
      smat_pkg::ST_MV_MARK_I: begin
        mark_raddr = MAW'(req_r.insert_facility);
      end
      smat_pkg::ST_MV_MARK_R: begin
        mi_nxt     = mark_rd;
        mark_raddr = MAW'(req_r.remove_facility);
      end
      smat_pkg::ST_MV_CHECK: begin
        mr_nxt    = mark_rd;
        scan_nxt  = '0;
        fnd_i_nxt = 1'b0;
        fnd_r_nxt = 1'b0;
        if (chk_fail) begin
          err_nxt = 1'b1;
        end
      end

      // move: search both lists
      smat_pkg::ST_MV_SCAN: begin
        if (cmp_i) begin
          fnd_i_nxt = 1'b1;
          ip_nxt    = pend_idx_r[AW-1:0];
        end
        if (cmp_r) begin
          fnd_r_nxt = 1'b1;
          rp_nxt    = pend_idx_r[AW-1:0];
        end
        if (scan_exit) begin
          err_nxt = !all_found;
        end else if (scan_issue) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = scan_r;
          scan_nxt     = scan_r + CW'(1);
        end
      end

      // move: fetch the last entries
      smat_pkg::ST_MV_LAST: begin
        ins_raddr = new_ins[AW-1:0];
        rem_raddr = new_rem[AW-1:0];
      end

      // move: swap-remove, update inserted facility marks
      smat_pkg::ST_MV_SWAP: begin
        ins_waddr = ip_r;
        ins_wdata = ins_rdata;
        rem_waddr = rp_r;
        rem_wdata = rem_rdata;
        ins_we    = iv;
        rem_we    = rv;
        if (iv) begin
          mark_we         = 1'b1;
          mark_waddr      = MAW'(req_r.insert_facility);
          mark_wdata.used = 1'b1;
          mark_wdata.ins  = 1'b0;
          mark_wdata.rem  = restore || mi_r.rem;
        end
        ins_tot_nxt = new_ins;
        rem_tot_nxt = new_rem;
      end

      // move: restore opposite options, update removed facility marks
      smat_pkg::ST_MV_APPEND: begin
        if (rv) begin
          mark_we         = 1'b1;
          mark_waddr      = MAW'(req_r.remove_facility);
          mark_wdata.used = 1'b0;
          mark_wdata.ins  = restore || mr_r.ins;
          mark_wdata.rem  = 1'b0;
        end
        if (restore && iv) begin
          rem_we      = 1'b1;
          rem_tot_nxt = rem_tot_r + CW'(1);
        end
        if (restore && rv) begin
          ins_we      = 1'b1;
          ins_tot_nxt = ins_tot_r + CW'(1);
        end
      end

      // hand result to the output register
      smat_pkg::ST_DONE: begin
        if (out_take) begin
          out_vld_nxt = 1'b1;
          out_ic_nxt  = smat_pkg::CNT_W'(ins_tot_r);
          out_rc_nxt  = smat_pkg::CNT_W'(rem_tot_r);
          out_ie_nxt  = ie_r;
          out_re_nxt  = re_r;
          out_err_nxt = err_r;
        end
      end

      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= smat_pkg::ST_IDLE;
      prl_r     <= 1'b0;
      ins_tot_r <= '0;
      rem_tot_r <= '0;
      pend_r    <= 1'b0;
      out_vld_r <= 1'b0;
      for (int i = 0; i < MDEPTH; i++) begin
        mark_vld_r[i] <= 1'b0;
      end
    end else begin
      state_r   <= state_nxt;
      ins_tot_r <= ins_tot_nxt;
      rem_tot_r <= rem_tot_nxt;
      pend_r    <= pend_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_we) begin
        prl_r <= cfg_wdata;
      end
      if (mark_we) begin
        mark_vld_r[mark_waddr] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    mi_r        <= mi_nxt;
    mr_r        <= mr_nxt;
    err_r       <= err_nxt;
    ie_r        <= ie_nxt;
    re_r        <= re_nxt;
    scan_r      <= scan_nxt;
    pend_idx_r  <= pend_idx_nxt;
    fnd_i_r     <= fnd_i_nxt;
    fnd_r_r     <= fnd_r_nxt;
    ip_r        <= ip_nxt;
    rp_r        <= rp_nxt;
    mark_rvld_r <= mark_vld_r[mark_raddr];
    out_ic_r    <= out_ic_nxt;
    out_rc_r    <= out_rc_nxt;
    out_ie_r    <= out_ie_nxt;
    out_re_r    <= out_re_nxt;
    out_err_r   <= out_err_nxt;
  end

  // Result channel
  assign out_ch.valid        = out_vld_r;
  assign out_ch.insert_count = out_ic_r;
  assign out_ch.remove_count = out_rc_r;
  assign out_ch.insert_entry = out_ie_r;
  assign out_ch.remove_entry = out_re_r;
  assign out_ch.error        = out_err_r;

  // ---------------------------------------------------------------------
  // Assertions
  logic [CW:0] tot_sum;
  assign tot_sum = (CW+1)'(ins_tot_r) + (CW+1)'(rem_tot_r);

  a_tot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ins_tot_r <= CW'(FACILITIES)) && (rem_tot_r <= CW'(FACILITIES)))
    else $error("list total above facility count");

  a_commit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == smat_pkg::ST_MV_SWAP || state_r == smat_pkg::ST_MV_APPEND)
    |-> (!err_r && (iv || rv)))
    else $error("move commits after a failed check");

  a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != smat_pkg::ST_MV_SCAN) |-> !pend_r)
    else $error("search read outstanding outside search");

  a_restore_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == smat_pkg::ST_MV_APPEND && !prl_r)
    |=> (tot_sum == $past(tot_sum, 2)))
    else $error("restoring move changed the total option count");

  a_done_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == smat_pkg::ST_DONE && out_take)
    |=> (out_vld_r && state_r == smat_pkg::ST_IDLE))
    else $error("finished request did not reach the output register");

endmodule

### design/smat_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
module smat_ram #(
  parameter int WIDTH = smat_pkg::FAC_W,
  parameter int DEPTH = smat_pkg::FACILITIES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### dv/swap_move_availability_table_test.sv
// Testbench for the swap move availability table: directed table, then random traffic.
module swap_move_availability_table_test;
  import smat_pkg::*;

  localparam int FACILITIES = FACILITIES_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 12;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // One result of the block
  typedef struct packed {
    logic [CNT_W-1:0] insert_count;
    logic [CNT_W-1:0] remove_count;
    logic [FAC_W-1:0] insert_entry;
    logic [FAC_W-1:0] remove_entry;
    logic             error;
  } tally_t;

  // One line of the directed table: a register write or a request
  typedef struct {
    bit     is_cfg;
    bit     cfg_val;
    req_t   req;
    bit     typed;
    tally_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  always #2 clk = ~clk;

  smat_in_if  in_ch ();
  smat_out_if out_ch ();

  swap_move_availability_table #(
    .FACILITIES (FACILITIES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the table
  bit             is_used    [FACILITIES];
  bit             can_insert [FACILITIES];
  bit             can_remove [FACILITIES];
  bit [FAC_W-1:0] ins_list   [FACILITIES];
  bit [FAC_W-1:0] rem_list   [FACILITIES];
  int             ins_total = 0;
  int             rem_total = 0;
  bit             relink_on = 1'b0;

  tally_t pending_tallies [$];
  row_t   dir_rows [$];
  int     fail_count = 0;
  int     send_idle = 0;
  int     recv_idle = 0;
  int     quiet_cycles = 0;

  // Request builders
  function automatic req_t mk_load(int f, int sol, int tgt);
    req_t r;
    r = '0;
    r.mode = MODE_LOAD;
    r.facility = FAC_W'(f);
    r.in_solution = 1'(sol);
    r.in_target = 1'(tgt);
    return r;
  endfunction

  function automatic req_t mk_move(int iv, int fi, int rv, int fr);
    req_t r;
    r = '0;
    r.mode = MODE_MOVE;
    r.insert_valid = 1'(iv);
    r.insert_facility = FAC_W'(fi);
    r.remove_valid = 1'(rv);
    r.remove_facility = FAC_W'(fr);
    return r;
  endfunction

  function automatic req_t mk_read(int p);
    req_t r;
    r = '0;
    r.mode = MODE_READ;
    r.position = FAC_W'(p);
    return r;
  endfunction

  function automatic tally_t tl(int ic, int rc, int ie, int re, int er);
    tally_t t;
    t.insert_count = CNT_W'(ic);
    t.remove_count = CNT_W'(rc);
    t.insert_entry = FAC_W'(ie);
    t.remove_entry = FAC_W'(re);
    t.error = 1'(er);
    return t;
  endfunction

  function automatic row_t req_row(req_t r, bit typed, tally_t want);
    row_t w;
    w.is_cfg = 1'b0;
    w.cfg_val = 1'b0;
    w.req = r;
    w.typed = typed;
    w.want = want;
    return w;
  endfunction

  function automatic row_t cfg_row(bit v);
    row_t w;
    w = req_row('0, 1'b0, '0);
    w.is_cfg = 1'b1;
    w.cfg_val = v;
    return w;
  endfunction

  // Linear search of the valid part of a list; -1 when absent
  function automatic int find_entry(bit in_rem, int f);
    int n;
    n = in_rem ? rem_total : ins_total;
    for (int i = 0; i < n && i < FACILITIES; i++) begin
      if (int'(in_rem ? rem_list[i] : ins_list[i]) == f) return i;
    end
    return -1;
  endfunction

  // Update the shadow table with one request and return its result
  function automatic tally_t apply_request(req_t r);
    tally_t t;
    int     f, fi, fr, ip, rp, new_ins, new_rem, p;
    bit     ok, iv, rv, ins, rem;
    t = '0;
    case (r.mode)
      MODE_LOAD: begin
        f = r.facility;
        if (f == 0) begin
          ins_total = 0;
          rem_total = 0;
        end
        ins = !r.in_solution && (!relink_on || r.in_target);
        rem = r.in_solution && (!relink_on || !r.in_target);
        is_used[f] = r.in_solution;
        can_insert[f] = ins;
        can_remove[f] = rem;
        // Full lists keep the mark but drop the entry
        if (ins && ins_total < FACILITIES) begin
          ins_list[ins_total] = FAC_W'(f);
          ins_total++;
        end
        if (rem && rem_total < FACILITIES) begin
          rem_list[rem_total] = FAC_W'(f);
          rem_total++;
        end
      end
      MODE_MOVE: begin
        iv = r.insert_valid;
        rv = r.remove_valid;
        fi = r.insert_facility;
        fr = r.remove_facility;
        ip = -1;
        rp = -1;
        ok = 1'b1;
        // All preconditions first; nothing changes on a reject
        if (iv) begin
          if (is_used[fi] || !can_insert[fi]) ok = 1'b0;
          else begin
            ip = find_entry(1'b0, fi);
            if (ip < 0 || (!relink_on && can_remove[fi])) ok = 1'b0;
          end
        end
        if (ok && rv) begin
          if (!is_used[fr] || !can_remove[fr]) ok = 1'b0;
          else begin
            rp = find_entry(1'b1, fr);
            if (rp < 0 || (!relink_on && can_insert[fr])) ok = 1'b0;
          end
        end
        new_ins = ins_total - int'(iv);
        new_rem = rem_total - int'(rv);
        if (ok && !relink_on &&
            ((iv && new_rem >= FACILITIES) || (rv && new_ins >= FACILITIES))) ok = 1'b0;
        t.error = !ok;
        if (ok) begin
          // Swap-remove from the own list
          if (iv) begin
            is_used[fi] = 1'b1;
            can_insert[fi] = 1'b0;
            ins_list[ip] = ins_list[new_ins];
            ins_total = new_ins;
          end
          if (rv) begin
            is_used[fr] = 1'b0;
            can_remove[fr] = 1'b0;
            rem_list[rp] = rem_list[new_rem];
            rem_total = new_rem;
          end
          // Without relinking the move can be undone later
          if (!relink_on) begin
            if (iv) begin
              can_remove[fi] = 1'b1;
              rem_list[rem_total] = FAC_W'(fi);
              rem_total++;
            end
            if (rv) begin
              can_insert[fr] = 1'b1;
              ins_list[ins_total] = FAC_W'(fr);
              ins_total++;
            end
          end
        end
      end
      MODE_READ: begin
        p = r.position;
        if (p < ins_total) t.insert_entry = ins_list[p];
        if (p < rem_total) t.remove_entry = rem_list[p];
      end
      default: ;
    endcase
    t.insert_count = CNT_W'(ins_total);
    t.remove_count = CNT_W'(rem_total);
    return t;
  endfunction

  // Random request picks, steered by the shadow lists
  function automatic req_t pick_move();
    int roll, fi, fr;
    bit iv, rv;
    roll = $urandom_range(99);
    iv = roll < 65;
    rv = (roll < 35) || (roll >= 65 && roll < 95);
    if (ins_total > 0 && $urandom_range(9) != 0) fi = ins_list[$urandom_range(ins_total - 1)];
    else fi = $urandom_range(255);
    if (rem_total > 0 && $urandom_range(9) != 0) fr = rem_list[$urandom_range(rem_total - 1)];
    else fr = $urandom_range(255);
    return mk_move(iv, fi, rv, fr);
  endfunction

  function automatic int pick_position();
    int top;
    top = (ins_total > rem_total) ? ins_total : rem_total;
    if (top > 0 && $urandom_range(9) < 8) return $urandom_range(top - 1);
    return $urandom_range(255);
  endfunction

  function automatic req_t random_item();
    req_t r;
    r.mode = 2'($urandom_range(3));
    r.facility = FAC_W'($urandom_range(255));
    r.in_solution = 1'($urandom_range(1));
    r.in_target = 1'($urandom_range(1));
    r.insert_valid = 1'($urandom_range(1));
    r.insert_facility = FAC_W'($urandom_range(255));
    r.remove_valid = 1'($urandom_range(1));
    r.remove_facility = FAC_W'($urandom_range(255));
    r.position = FAC_W'($urandom_range(255));
    return r;
  endfunction

  // Drive one request, wait for it to be taken, then record its expected result
  task automatic send_request(req_t r, bit typed, tally_t want);
    tally_t pred;
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.mode = r.mode;
    in_ch.facility = r.facility;
    in_ch.in_solution = r.in_solution;
    in_ch.in_target = r.in_target;
    in_ch.insert_valid = r.insert_valid;
    in_ch.insert_facility = r.insert_facility;
    in_ch.remove_valid = r.remove_valid;
    in_ch.remove_facility = r.remove_facility;
    in_ch.position = r.position;
    in_ch.valid = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = apply_request(r);
    pending_tallies.push_back(typed ? want : pred);
  endtask

  // Register write once the block has gone quiet
  task automatic write_relink(bit v);
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wdata = v;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    relink_on = v;
  endtask

  task automatic random_ops(int n);
    int roll;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      if (roll < 65) send_request(pick_move(), 1'b0, '0);
      else if (roll < 95) send_request(mk_read(pick_position()), 1'b0, '0);
      else send_request(random_item(), 1'b0, '0);
    end
  endtask

  // Ascending loads from facility 0 with random membership
  task automatic build_set(int n);
    for (int f = 0; f < n; f++) begin
      send_request(mk_load(f, $urandom_range(1), $urandom_range(1)), 1'b0, '0);
    end
  endtask

  task automatic run_phase(int items, int s_idle, int r_idle);
    int done, roll, n, ops;
    send_idle = s_idle;
    recv_idle = r_idle;
    done = 0;
    while (done < items) begin
      roll = $urandom_range(99);
      if (roll < 60) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(80, 25) : $urandom_range(24, 2);
        ops = $urandom_range(16, 4);
        build_set(n);
        random_ops(ops);
        done += n + ops;
      end else if (roll < 80) begin
        ops = $urandom_range(12, 2);
        random_ops(ops);
        done += ops;
      end else begin
        // Noise: arbitrary requests, loads out of order among them
        ops = $urandom_range(6, 1);
        for (int k = 0; k < ops; k++) send_request(random_item(), 1'b0, '0);
        done += ops;
      end
    end
  endtask

  // Overfill one list with relinking off, then try a move whose append overflows
  task automatic flood_list(bit sol);
    send_request(mk_load(0, !sol, 1), 1'b0, '0);
    for (int k = 0; k < FACILITIES + 1; k++) begin
      send_request(mk_load($urandom_range(255, 1), sol, $urandom_range(1)), 1'b0, '0);
    end
    if (sol) send_request(mk_move(1, 0, 0, 0), 1'b0, '0);
    else send_request(mk_move(0, 0, 1, 0), 1'b0, '0);
    send_request(mk_read(FACILITIES - 1), 1'b0, '0);
    random_ops(12);
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  // Compare each result with the oldest expectation
  function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                      logic [CNT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    tally_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_tallies.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got %0d/%0d/%0d/%0d/%0d",
                 $time, out_ch.insert_count, out_ch.remove_count, out_ch.insert_entry,
                 out_ch.remove_entry, out_ch.error);
        fail_count++;
      end else begin
        want = pending_tallies.pop_front();
        check_field("insert_count", want.insert_count, out_ch.insert_count);
        check_field("remove_count", want.remove_count, out_ch.remove_count);
        check_field("insert_entry", want.insert_entry, out_ch.insert_entry);
        check_field("remove_entry", want.remove_entry, out_ch.remove_entry);
        check_field("error", want.error, out_ch.error);
      end
    end
  end

  // Watchdog: too long without any handshake
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_LOAD;
    in_ch.facility = '0;
    in_ch.in_solution = 1'b0;
    in_ch.in_target = 1'b0;
    in_ch.insert_valid = 1'b0;
    in_ch.insert_facility = '0;
    in_ch.remove_valid = 1'b0;
    in_ch.remove_facility = '0;
    in_ch.position = '0;
    out_ch.ready = 1'b0;

    // Directed table, relinking off
    dir_rows.push_back(cfg_row(1'b0));
    dir_rows.push_back(req_row(mk_read(0), 1'b1, tl(0, 0, 0, 0, 0)));
    dir_rows.push_back(req_row('1, 1'b1, tl(0, 0, 0, 0, 0)));
    dir_rows.push_back(req_row(mk_move(0, 255, 0, 255), 1'b1, tl(0, 0, 0, 0, 0)));
    dir_rows.push_back(req_row(mk_move(1, 255, 0, 0), 1'b1, tl(0, 0, 0, 0, 1)));
    dir_rows.push_back(req_row(mk_load(0, 0, 1), 1'b1, tl(1, 0, 0, 0, 0)));
    dir_rows.push_back(req_row(mk_load(1, 1, 1), 1'b1, tl(1, 1, 0, 0, 0)));
    dir_rows.push_back(req_row(mk_load(2, 0, 0), 1'b1, tl(2, 1, 0, 0, 0)));
    dir_rows.push_back(req_row(mk_load(3, 1, 0), 1'b1, tl(2, 2, 0, 0, 0)));
    dir_rows.push_back(req_row(mk_load(255, 1, 1), 1'b1, tl(2, 3, 0, 0, 0)));
    dir_rows.push_back(req_row(mk_read(2), 1'b1, tl(2, 3, 0, 255, 0)));
    dir_rows.push_back(req_row(mk_move(1, 0, 1, 1), 1'b0, '0));
    dir_rows.push_back(req_row(mk_move(1, 0, 0, 0), 1'b1, tl(2, 3, 0, 0, 1)));
    dir_rows.push_back(req_row(mk_move(0, 0, 1, 2), 1'b0, '0));
    dir_rows.push_back(req_row(mk_read(0), 1'b0, '0));
    dir_rows.push_back(req_row(mk_read(255), 1'b0, '0));
    dir_rows.push_back(req_row(mk_move(1, 2, 0, 0), 1'b0, '0));
    dir_rows.push_back(req_row(mk_move(0, 0, 1, 255), 1'b0, '0));
    dir_rows.push_back(req_row(mk_read(1), 1'b0, '0));
    // Relinking on: loads qualified by the target, no restore
    dir_rows.push_back(cfg_row(1'b1));
    dir_rows.push_back(req_row(mk_load(0, 0, 1), 1'b1, tl(1, 0, 0, 0, 0)));
    dir_rows.push_back(req_row(mk_load(1, 0, 0), 1'b1, tl(1, 0, 0, 0, 0)));
    dir_rows.push_back(req_row(mk_load(2, 1, 0), 1'b1, tl(1, 1, 0, 0, 0)));
    dir_rows.push_back(req_row(mk_load(3, 1, 1), 1'b1, tl(1, 1, 0, 0, 0)));
    dir_rows.push_back(req_row(mk_move(1, 1, 0, 0), 1'b1, tl(1, 1, 0, 0, 1)));
    dir_rows.push_back(req_row(mk_move(1, 0, 1, 2), 1'b1, tl(0, 0, 0, 0, 0)));
    dir_rows.push_back(req_row(mk_read(0), 1'b1, tl(0, 0, 0, 0, 0)));

    // Reset
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle = 34;
    recv_idle = 70;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_relink(dir_rows[i].cfg_val);
      else send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases with changing pressure and register settings
    write_relink(1'b0);
    run_phase(300, 34, 70);
    write_relink(1'b1);
    run_phase(300, 70, 34);
    write_relink(1'b0);
    run_phase(100, 0, 0);
    flood_list(1'b0);
    flood_list(1'b1);
    write_relink(1'b1);
    run_phase(60, 0, 0);

    // Drain
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
